// ----- hdl/sra_pkg.sv -----
// ----------------------------------------------------------------------------
// Signed radix to ASCII package
// Shared constants, types and the digit to character mapping.
// ----------------------------------------------------------------------------
`default_nettype none

package sra_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned DIGIT_DEPTH_DEF = 32;

  localparam int unsigned RADIX_W   = 6;
  localparam int unsigned DIGIT_W   = 6;
  localparam int unsigned CHAR_W    = 7;
  localparam int unsigned STEP_BITS = 4;  // dividend bits retired per divider cycle

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

  localparam logic [CHAR_W-1:0]  CHAR_MINUS       = 7'd45;
  localparam logic [CHAR_W-1:0]  CHAR_DIGIT_BASE  = 7'd48;
  localparam logic [CHAR_W-1:0]  CHAR_LETTER_BASE = 7'd55;
  localparam logic [DIGIT_W-1:0] DECIMAL_LIMIT    = 6'd10;

  typedef struct packed {
    logic               neg;
    logic [RADIX_W-1:0] radix;
  } sra_cls_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_READ,
    ST_EMIT
  } sra_state_e;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DECIMAL_LIMIT) begin
      c = CHAR_DIGIT_BASE + {1'b0, d};
    end else begin
      c = CHAR_LETTER_BASE + {1'b0, d};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/sra_in_if.sv -----
// ----------------------------------------------------------------------------
// Input channel
// Valid/ready channel carrying one signed value and its radix.
// ----------------------------------------------------------------------------
`default_nettype none

interface sra_in_if #(
  parameter int unsigned VALUE_WIDTH = sra_pkg::VALUE_WIDTH_DEF
);
  import sra_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] value;
  logic [RADIX_W-1:0]     radix;

  modport source (output valid, output value, output radix, input ready);
  modport sink   (input valid, input value, input radix, output ready);
endinterface

`default_nettype wire

// ----- hdl/sra_out_if.sv -----
// ----------------------------------------------------------------------------
// Output channel
// Valid/ready channel carrying one ASCII character and its end marker.
// ----------------------------------------------------------------------------
`default_nettype none

interface sra_out_if;
  import sra_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

`default_nettype wire

// ----- hdl/sra_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sra_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/sra_front.sv -----
// ----------------------------------------------------------------------------
// Front end
// Accepts items, clamps the radix and splits the value into sign and
// magnitude for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sra_front #(
  parameter int unsigned VALUE_WIDTH = sra_pkg::VALUE_WIDTH_DEF
) (
  sra_in_if.sink                       in_i,
  output logic                         push_valid_o,
  input  wire logic                    push_ready_i,
  output sra_pkg::sra_cls_t            push_cls_o,
  output logic [VALUE_WIDTH-1:0]       push_mag_o
);
  import sra_pkg::*;

  logic neg;

  assign neg          = in_i.value[VALUE_WIDTH-1];
  assign push_valid_o = in_i.valid;
  assign in_i.ready   = push_ready_i;

  // The most negative value negates to itself, which read unsigned is its magnitude.
  assign push_mag_o = neg ? (~in_i.value + VALUE_WIDTH'(1)) : in_i.value;

  always_comb begin
    push_cls_o.neg = neg;
    if (in_i.radix < RADIX_MIN) begin
      push_cls_o.radix = RADIX_MIN;
    end else if (in_i.radix > RADIX_MAX) begin
      push_cls_o.radix = RADIX_MAX;
    end else begin
      push_cls_o.radix = in_i.radix;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/sra_queue.sv -----
// ----------------------------------------------------------------------------
// Item queue
// Short FIFO between the front end and the conversion engine.
// ----------------------------------------------------------------------------
`default_nettype none

module sra_queue #(
  parameter int unsigned VALUE_WIDTH = sra_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    push_valid_i,
  output logic                         push_ready_o,
  input  wire sra_pkg::sra_cls_t       push_cls_i,
  input  wire logic [VALUE_WIDTH-1:0]  push_mag_i,
  output logic                         pop_valid_o,
  input  wire logic                    pop_ready_i,
  output sra_pkg::sra_cls_t            pop_cls_o,
  output logic [VALUE_WIDTH-1:0]       pop_mag_o
);
  import sra_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  sra_cls_t               cls_q [QUEUE_DEPTH];
  logic [VALUE_WIDTH-1:0] mag_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic                   push, pop;

  assign push_ready_o = (cnt_q != CNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_cls_o    = cls_q[rd_ptr_q];
  assign pop_mag_o    = mag_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? PTR_W'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = pop  ? PTR_W'(rd_ptr_q + 1'b1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      cls_q[wr_ptr_q] <= push_cls_i;
      mag_q[wr_ptr_q] <= push_mag_i;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/sra_back.sv -----
// ----------------------------------------------------------------------------
// Conversion engine
// Divides the magnitude by the radix one digit at a time, stores the digits
// and emits them as ASCII characters, most significant first.
// ----------------------------------------------------------------------------
`default_nettype none

module sra_back #(
  parameter int unsigned VALUE_WIDTH = sra_pkg::VALUE_WIDTH_DEF,
  parameter int unsigned DIGIT_DEPTH = sra_pkg::DIGIT_DEPTH_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    q_valid_i,
  output logic                         q_ready_o,
  input  wire sra_pkg::sra_cls_t       q_cls_i,
  input  wire logic [VALUE_WIDTH-1:0]  q_mag_i,
  sra_out_if.source                    out_o
);
  import sra_pkg::*;

  localparam int unsigned PAD_W  = ((VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
  localparam int unsigned STEPS  = PAD_W / STEP_BITS;
  localparam int unsigned STEP_CW = $clog2(STEPS);
  localparam int unsigned CNT_W  = $clog2(DIGIT_DEPTH + 1);
  localparam int unsigned ADDR_W = $clog2(DIGIT_DEPTH);

  sra_state_e         state_q, state_d;
  logic [PAD_W-1:0]   quot_q, quot_d, quot_shift;
  logic [DIGIT_W-1:0] rem_q, rem_d, rem_n;
  logic [RADIX_W-1:0] radix_q, radix_d;
  logic               neg_q, neg_d;
  logic [STEP_CW-1:0] step_q, step_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d, cnt_m1;
  logic               out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]  out_char_q, out_char_d;
  logic               out_last_q, out_last_d;
  logic [STEP_BITS-1:0] qbits;
  logic               last_step, next_zero, out_free;
  logic               ram_we, ram_re;
  logic [DIGIT_W-1:0] ram_rdata;

  // Restoring division: each cycle shifts STEP_BITS dividend bits into the
  // remainder and shifts the matching quotient bits into the low end.
  always_comb begin : div_step
    logic [DIGIT_W:0] trial;
    rem_n = rem_q;
    qbits = '0;
    for (int i = 0; i < STEP_BITS; i++) begin
      trial = {rem_n, quot_q[PAD_W-1-i]};
      if (trial >= {1'b0, radix_q}) begin
        rem_n = DIGIT_W'(trial - {1'b0, radix_q});
        qbits[STEP_BITS-1-i] = 1'b1;
      end else begin
        rem_n = trial[DIGIT_W-1:0];
      end
    end
  end

  assign quot_shift = {quot_q[PAD_W-STEP_BITS-1:0], qbits};
  assign last_step  = (step_q == STEP_CW'(STEPS - 1));
  assign next_zero  = (quot_shift == '0);
  assign out_free   = !out_valid_q || out_o.ready;
  assign cnt_m1     = cnt_q - CNT_W'(1);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (last_step && next_zero) begin
          state_d = neg_q ? ST_SIGN : ST_READ;
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = (cnt_q == CNT_W'(1)) ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    q_ready_o   = 1'b0;
    quot_d      = quot_q;
    rem_d       = rem_q;
    radix_d     = radix_q;
    neg_d       = neg_q;
    step_d      = step_q;
    cnt_d       = cnt_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    out_valid_d = out_free ? 1'b0 : out_valid_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    unique case (state_q)
      ST_IDLE: begin
        q_ready_o = 1'b1;
        if (q_valid_i) begin
          quot_d  = PAD_W'(q_mag_i);
          rem_d   = '0;
          radix_d = q_cls_i.radix;
          neg_d   = q_cls_i.neg;
          step_d  = '0;
          cnt_d   = '0;
        end
      end
      ST_DIV: begin
        quot_d = quot_shift;
        rem_d  = rem_n;
        step_d = step_q + STEP_CW'(1);
        if (last_step) begin
          step_d = '0;
          rem_d  = '0;
          // Digits beyond the store depth are the most significant ones and are dropped.
          if (cnt_q < CNT_W'(DIGIT_DEPTH)) begin
            ram_we = 1'b1;
            cnt_d  = cnt_q + CNT_W'(1);
          end
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = CHAR_MINUS;
          out_last_d  = 1'b0;
        end
      end
      ST_READ: begin
        ram_re = 1'b1;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = digit_char(ram_rdata);
          out_last_d  = (cnt_q == CNT_W'(1));
          cnt_d       = cnt_m1;
        end
      end
      default: begin
      end
    endcase
  end

  sra_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (DIGIT_DEPTH)
  ) u_digit_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[ADDR_W-1:0]),
    .wdata_i (rem_n),
    .re_i    (ram_re),
    .raddr_i (cnt_m1[ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      cnt_q       <= '0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      cnt_q       <= cnt_d;
      neg_q       <= neg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q     <= quot_d;
    rem_q      <= rem_d;
    radix_q    <= radix_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.char_code = out_char_q;
  assign out_o.last      = out_last_q;

endmodule

`default_nettype wire

// ----- hdl/signed_radix_to_ascii.sv -----
// ----------------------------------------------------------------------------
// Signed radix to ASCII converter
// Turns a signed integer into its text in radix 2 to 36, one ASCII character
// per transfer, most significant first, led by a minus sign when negative.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Payload                     Notes
//   in_i     in   value, radix                one number per transfer
//   out_o    out  char_code, last             one character per transfer
//
// An item passes through the queue hand-off, then the four-bit-per-cycle divider
// once per digit, then the registered digit RAM read once per character, with
// the sign emitted first for a negative value.
// The front end keeps taking items into a two-entry queue while the engine
// works, until the queue is full. The digit RAM needs no clearing pass after reset.
`default_nettype none

module signed_radix_to_ascii #(
  parameter int unsigned VALUE_WIDTH = sra_pkg::VALUE_WIDTH_DEF,
  parameter int unsigned DIGIT_DEPTH = sra_pkg::DIGIT_DEPTH_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sra_in_if.sink    in_i,
  sra_out_if.source out_o
);
  import sra_pkg::*;

  logic                   push_valid, push_ready;
  sra_cls_t               push_cls;
  logic [VALUE_WIDTH-1:0] push_mag;
  logic                   q_valid, q_ready;
  sra_cls_t               q_cls;
  logic [VALUE_WIDTH-1:0] q_mag;

  sra_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cls_o   (push_cls),
    .push_mag_o   (push_mag)
  );

  sra_queue #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cls_i   (push_cls),
    .push_mag_i   (push_mag),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_cls_o    (q_cls),
    .pop_mag_o    (q_mag)
  );

  sra_back #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .DIGIT_DEPTH (DIGIT_DEPTH)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_ready_o (q_ready),
    .q_cls_i   (q_cls),
    .q_mag_i   (q_mag),
    .out_o     (out_o)
  );

  // Every emitted character is a minus sign, a decimal digit or an upper-case letter.
  a_char_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.char_code == CHAR_MINUS) ||
                    (out_o.char_code >= CHAR_DIGIT_BASE &&
                     out_o.char_code < CHAR_DIGIT_BASE + CHAR_W'(DECIMAL_LIMIT)) ||
                    (out_o.char_code >= CHAR_LETTER_BASE + CHAR_W'(DECIMAL_LIMIT) &&
                     out_o.char_code < CHAR_LETTER_BASE + CHAR_W'(RADIX_MAX)))
    else $error("illegal character code on output");

  // The sign always precedes digits, so it never ends a number.
  a_sign_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.char_code == CHAR_MINUS) |-> !out_o.last)
    else $error("minus sign flagged as last character");

  // Once the engine takes an item it is busy until that number is emitted.
  a_engine_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid && q_ready) |=> !q_ready)
    else $error("engine took two items back to back");

endmodule

`default_nettype wire
